// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the serial line editor.
// ASSERT_ALWAYS checks that a condition holds at every clock edge outside reset.
// ASSERT_NEXT checks that a consequent holds in the cycle after its antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Serial line editor package
// Character codes, command table, queue entry type and the command match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

	localparam int LINE_DEPTH_DEF = 64;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam int CODE_W = 3;
	localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

	localparam int NUM_CMDS    = 5;
	localparam int PREFIX_LEN  = 6;
	localparam int PREFIX_IDX_W = $clog2(PREFIX_LEN);
	localparam int LEN_CLIP_W  = $clog2(PREFIX_LEN + 2);

	typedef logic [7:0] prefix_t [PREFIX_LEN];
	typedef logic [7:0] cmd_text_t [NUM_CMDS][PREFIX_LEN];
	typedef logic [LEN_CLIP_W-1:0] cmd_len_t [NUM_CMDS];

	// On, Off, --v, uptime, volt
	localparam cmd_text_t CMD_TEXT = '{
		'{8'h4F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h4F, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00},
		'{8'h2D, 8'h2D, 8'h76, 8'h00, 8'h00, 8'h00},
		'{8'h75, 8'h70, 8'h74, 8'h69, 8'h6D, 8'h65},
		'{8'h76, 8'h6F, 8'h6C, 8'h74, 8'h00, 8'h00}
	};
	localparam cmd_len_t CMD_LEN = '{3'd2, 3'd3, 3'd3, 3'd6, 3'd4};

	localparam logic [1:0] KIND_ECHO  = 2'd0;
	localparam logic [1:0] KIND_ERASE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        ch;
		logic [CODE_W-1:0] code;
	} op_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [CODE_W-1:0] match_cmd(input prefix_t p,
		input logic [LEN_CLIP_W-1:0] len);
		logic [CODE_W-1:0] code;
		logic              eq;
		code = CODE_NONE;
		for (int c = NUM_CMDS - 1; c >= 0; c--) begin
			eq = (len == CMD_LEN[c]);
			for (int i = 0; i < PREFIX_LEN; i++) begin
				if ((LEN_CLIP_W'(i) < len) && (p[i] != CMD_TEXT[c][i])) begin
					eq = 1'b0;
				end
			end
			if (eq) begin
				code = CODE_W'(c + 1);
			end
		end
		return code;
	endfunction

endpackage

// File: rtl/sle_front.sv
// ----------------------------------------------------------------------------
// Serial line editor front end
// Accepts received bytes, keeps the fill count and the line head, and queues
// one operation for every byte that produces an echo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_front #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    rx_byte,
	input  logic          q_full,
	output logic          q_push,
	output sle_pkg::op_t  q_data
);
	import sle_pkg::*;

	localparam int FILL_W = $clog2(LINE_DEPTH + 1);

	logic [FILL_W-1:0]     fill_q;
	prefix_t               prefix_q;
	logic                  accept;
	logic                  is_erase;
	logic                  is_end;
	logic                  not_empty;
	logic                  not_full;
	logic                  do_erase;
	logic                  do_store;
	logic [LEN_CLIP_W-1:0] len_clip;

	assign in_stall = q_full;

	// Only the first characters of the line can take part in a command match,
	// so only those are kept; a longer line clips to a length no command has.
	always_comb begin
		accept    = in_valid & ~q_full;
		is_erase  = rx_byte inside {CH_BS, CH_DEL};
		is_end    = rx_byte inside {CH_CR, CH_LF};
		not_empty = (fill_q != '0);
		not_full  = (fill_q != FILL_W'(LINE_DEPTH));
		do_erase  = accept & is_erase & not_empty;
		do_store  = accept & ~is_erase & ~is_end & not_full;
		q_push    = do_erase | do_store | (accept & is_end);
		len_clip  = (fill_q > FILL_W'(PREFIX_LEN)) ? LEN_CLIP_W'(PREFIX_LEN + 1)
			: fill_q[LEN_CLIP_W-1:0];
		q_data.ch   = rx_byte;
		q_data.code = CODE_NONE;
		if (is_erase) begin
			q_data.kind = KIND_ERASE;
		end else if (is_end) begin
			q_data.kind = KIND_END;
			q_data.code = match_cmd(prefix_q, len_clip);
		end else begin
			q_data.kind = KIND_ECHO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept & is_end) begin
			fill_q <= '0;
		end else if (do_erase) begin
			fill_q <= fill_q - 1'b1;
		end else if (do_store) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_store && (fill_q < FILL_W'(PREFIX_LEN))) begin
			prefix_q[fill_q[PREFIX_IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

// File: rtl/sle_queue.sv
// ----------------------------------------------------------------------------
// Serial line editor operation queue
// A short first-in first-out queue between the front end and the echo stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  sle_pkg::op_t push_data,
	output logic         full,
	input  logic         pop,
	output logic         head_valid,
	output sle_pkg::op_t head_data
);
	import sle_pkg::*;

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/sle_back.sv
// ----------------------------------------------------------------------------
// Serial line editor echo stage
// Expands each queued operation into its echo beats and holds them in the
// output register until they are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sle_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  sle_pkg::op_t               head_data,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 echo_byte,
	output logic                       last,
	output logic                       line_done,
	output logic [sle_pkg::CODE_W-1:0] command_code
);
	import sle_pkg::*;

	logic [1:0]        beat_q;
	logic              out_valid_q;
	logic [7:0]        echo_q;
	logic              last_q;
	logic              done_q;
	logic [CODE_W-1:0] code_q;
	logic              free;
	logic              load;
	logic [7:0]        beat_ch;
	logic              beat_last;
	logic              beat_done;
	logic [CODE_W-1:0] beat_code;

	always_comb begin
		free      = ~out_valid_q | ~out_stall;
		load      = free & head_valid;
		beat_ch   = head_data.ch;
		beat_last = 1'b1;
		beat_done = 1'b0;
		beat_code = CODE_NONE;
		case (head_data.kind)
			KIND_ERASE: begin
				beat_ch   = (beat_q == 2'd1) ? CH_SP : CH_BS;
				beat_last = (beat_q == 2'd2);
			end
			KIND_END: begin
				beat_ch   = (beat_q == 2'd0) ? CH_CR : CH_LF;
				beat_last = (beat_q != 2'd0);
				beat_done = beat_last;
				beat_code = beat_last ? head_data.code : CODE_NONE;
			end
			default: begin
				beat_ch   = head_data.ch;
				beat_last = 1'b1;
			end
		endcase
		pop = load & beat_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (free) begin
				out_valid_q <= head_valid;
			end
			if (pop) begin
				beat_q <= 2'd0;
			end else if (load) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			echo_q <= beat_ch;
			last_q <= beat_last;
			done_q <= beat_done;
			code_q <= beat_code;
		end
	end

	assign out_valid    = out_valid_q;
	assign echo_byte    = echo_q;
	assign last         = last_q;
	assign line_done    = done_q;
	assign command_code = code_q;

	`ASSERT_ALWAYS(a_done_on_last, clk, arst_n, !(out_valid_q && done_q) || last_q)
	`ASSERT_ALWAYS(a_code_on_done, clk, arst_n, !(out_valid_q && code_q != CODE_NONE) || done_q)
	`ASSERT_NEXT(a_beat_restart, clk, arst_n, pop, beat_q == 2'd0)
	`ASSERT_ALWAYS(a_beat_range, clk, arst_n, beat_q != 2'd3)

endmodule

// File: rtl/serial_line_editor_command_match.sv
// The first echo beat of a byte passes through the queue and then the output register.
// The output register gives one echo beat per cycle while the queue is not empty and out_stall
// is low; a stored byte gives one beat, a line end two and an erase three, set by the echo stage's beat counter.
// A two-entry queue lets bytes be accepted while the output is stalled.
// Reset clears the fill count, the queue and the output valid; the line head is not cleared.
// ----------------------------------------------------------------------------
// Serial line editor with command match
// Echoes received terminal bytes, handles erase and line end, and reports the
// fixed command that a finished line matched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_line_editor_command_match #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 echo_byte,
	output logic                       last,
	output logic                       line_done,
	output logic [sle_pkg::CODE_W-1:0] command_code
);
	import sle_pkg::*;

	logic q_full;
	logic q_push;
	op_t  q_data;
	logic q_pop;
	logic q_head_valid;
	op_t  q_head;

	sle_front #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	sle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head)
	);

	sle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_head_valid),
		.head_data    (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.echo_byte    (echo_byte),
		.last         (last),
		.line_done    (line_done),
		.command_code (command_code)
	);

endmodule

// File: tb/sv/tb_serial_line_editor_command_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line editor testbench
// Sends terminal bytes to the line editor with random gaps. It stalls the
// echo side at random. Each echo beat is checked against a line model that
// keeps its own line buffer and command table.
// ----------------------------------------------------------------------------

module tb_serial_line_editor_command_match;
	import sle_pkg::*;

	localparam int LINE_LEN   = LINE_DEPTH_DEF;
	localparam int ITEM_COUNT = 430;
	localparam int CYCLE_CAP  = 400000;

	typedef struct packed {
		logic [7:0]        ch;
		logic              fin;
		logic              done;
		logic [CODE_W-1:0] code;
	} echo_beat_t;

	string cmd_names[NUM_CMDS] = '{"On", "Off", "--v", "uptime", "volt"};

	class line_echo_predictor;
		logic [7:0]   line_buf[LINE_LEN];
		int unsigned  fill;
		echo_beat_t   echo_due[$];
		int unsigned  faults;
		int unsigned  productive;

		function new();
			fill = 0;
			faults = 0;
			productive = 0;
		endfunction

		function logic [CODE_W-1:0] lookup_code();
			logic [CODE_W-1:0] code;
			bit                same;
			code = CODE_NONE;
			for (int c = 0; c < NUM_CMDS; c++) begin
				if (code == CODE_NONE && cmd_names[c].len() == fill) begin
					same = 1'b1;
					for (int i = 0; i < fill; i++) begin
						if (line_buf[i] != cmd_names[c][i]) begin
							same = 1'b0;
						end
					end
					if (same) begin
						code = CODE_W'(c + 1);
					end
				end
			end
			return code;
		endfunction

		function void note_rx_byte(logic [7:0] b);
			logic [CODE_W-1:0] code;
			if (b == CH_BS || b == CH_DEL) begin
				if (fill != 0) begin
					fill--;
					echo_due.push_back('{CH_BS, 1'b0, 1'b0, CODE_NONE});
					echo_due.push_back('{CH_SP, 1'b0, 1'b0, CODE_NONE});
					echo_due.push_back('{CH_BS, 1'b1, 1'b0, CODE_NONE});
					productive++;
				end
			end else if (b == CH_CR || b == CH_LF) begin
				code = lookup_code();
				fill = 0;
				echo_due.push_back('{CH_CR, 1'b0, 1'b0, CODE_NONE});
				echo_due.push_back('{CH_LF, 1'b1, 1'b1, code});
				productive++;
			end else if (fill < LINE_LEN) begin
				line_buf[fill] = b;
				fill++;
				echo_due.push_back('{b, 1'b1, 1'b0, CODE_NONE});
				productive++;
			end
		endfunction

		function void check_echo_beat(echo_beat_t got);
			echo_beat_t want;
			if (echo_due.size() == 0) begin
				if (faults < 10) begin
					$display("unexpected echo beat: byte %02h last %0d done %0d code %0d",
						got.ch, got.fin, got.done, got.code);
				end
				faults++;
			end else begin
				want = echo_due.pop_front();
				if (want !== got) begin
					if (faults < 10) begin
						$display({"echo mismatch: expected byte %02h last %0d done %0d code %0d,",
							" got byte %02h last %0d done %0d code %0d"},
							want.ch, want.fin, want.done, want.code,
							got.ch, got.fin, got.done, got.code);
					end
					faults++;
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        echo_byte;
	logic              last;
	logic              line_done;
	logic [CODE_W-1:0] command_code;

	line_echo_predictor line_model = new();
	int unsigned        cycles;
	bit                 quiet_in;

	serial_line_editor_command_match u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.echo_byte    (echo_byte),
		.last         (last),
		.line_done    (line_done),
		.command_code (command_code)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cycles = 0;
		quiet_in = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("tb_serial_line_editor_command_match: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				line_model.note_rx_byte(rx_byte);
			end
			if (out_valid && !out_stall) begin
				line_model.check_echo_beat('{echo_byte, last, line_done, command_code});
			end
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 9) < 3) begin
				out_stall <= 1'b0;
				n = $urandom_range(20, 80);
			end else begin
				out_stall <= 1'($urandom_range(0, 1));
				n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
			end
			repeat (n) @(posedge clk);
		end
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_in || r < 50) begin
			return 0;
		end
		return (r < 85) ? $urandom_range(1, 3) : $urandom_range(6, 30);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(0, 255));
		end while (b == CH_BS || b == CH_DEL || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] end_char();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	function automatic logic [7:0] erase_char();
		return $urandom_range(0, 1) ? CH_BS : CH_DEL;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		foreach (seq[i]) begin
			send_byte(seq[i]);
		end
	endtask

	task automatic send_text(input string s, input logic [7:0] tail);
		logic [7:0] seq[$];
		for (int i = 0; i < s.len(); i++) begin
			seq.push_back(s[i]);
		end
		seq.push_back(tail);
		send_seq(seq);
	endtask

	task automatic random_burst();
		logic [7:0] seq[$];
		string      s;
		int         kind;
		int         n;
		int         pos;
		kind = $urandom_range(0, 99);
		s = cmd_names[$urandom_range(0, NUM_CMDS - 1)];
		for (int i = 0; i < s.len(); i++) begin
			seq.push_back(s[i]);
		end
		if (kind < 35) begin
			if ($urandom_range(0, 9) < 3) begin
				pos = $urandom_range(0, seq.size());
				seq.insert(pos, erase_char());
				seq.insert(pos, plain_char());
			end
		end else if (kind < 55) begin
			case ($urandom_range(0, 3))
				0: void'(seq.pop_back());
				1: seq.push_back(plain_char());
				2: begin
					pos = $urandom_range(0, seq.size() - 1);
					seq[pos] = seq[pos] ^ 8'h01;
				end
				default: seq.push_front(8'h00);
			endcase
		end else if (kind < 65) begin
			seq.delete();
			n = $urandom_range(0, 10);
			repeat (n) seq.push_back(plain_char());
		end else if (kind < 68 || (line_model.productive > 150 && kind < 80 &&
			line_model.fill == 0 && seq.size() == 2)) begin
			seq.delete();
			n = LINE_LEN + $urandom_range(1, 4);
			repeat (n) seq.push_back(plain_char());
			n = $urandom_range(0, 3);
			repeat (n) seq.push_back(erase_char());
		end else if (kind < 80) begin
			seq.delete();
			n = $urandom_range(0, 3);
			repeat (n) seq.push_back(plain_char());
			n = n + $urandom_range(1, 3);
			repeat (n) seq.push_back(erase_char());
		end else begin
			seq.delete();
			n = $urandom_range(1, 8);
			repeat (n) seq.push_back(8'($urandom_range(0, 255)));
			send_seq(seq);
			return;
		end
		seq.push_back(end_char());
		if ($urandom_range(0, 3) == 0) begin
			seq.push_back(CH_LF);
		end
		send_seq(seq);
	endtask

	initial begin
		logic [7:0] seq[$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		seq = '{CH_BS, CH_DEL};
		send_seq(seq);
		send_text("On", CH_CR);
		send_text("Off", CH_LF);
		send_text("--v", CH_CR);
		send_byte(CH_LF);
		seq = '{8'h00, 8'hFF, CH_DEL};
		send_seq(seq);
		send_text("uptime", CH_CR);
		send_text("volt", CH_LF);

		while (line_model.productive < ITEM_COUNT) begin
			quiet_in = ($urandom_range(0, 5) == 0);
			random_burst();
		end
		in_valid <= 1'b0;

		while (line_model.echo_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (line_model.faults == 0 && line_model.echo_due.size() == 0) begin
			$display("tb_serial_line_editor_command_match: done, clean");
		end else begin
			$display("tb_serial_line_editor_command_match: done, errors");
		end
		$finish;
	end

endmodule
